FILE: hdl/ranked_sorted_set_assert.svh
// ----------------------------------------------------------------------------
// ranked_sorted_set assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef RANKED_SORTED_SET_ASSERT_SVH
`define RANKED_SORTED_SET_ASSERT_SVH

// condition holds at every edge
`define RSS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define RSS_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RSS_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// shared constants and types of the ranked sorted set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rss_pkg;

	localparam int CAPACITY   = 1024;
	localparam int VALUE_BITS = 17;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int OCC_W      = $clog2(CAPACITY + 1);
	localparam int POS_W      = 10;
	localparam int ST_W       = 2;

	// cells per first-level encoder group
	localparam int GRP_SZ = 32;
	localparam int GRP_W  = $clog2(GRP_SZ);
	localparam int NGRP   = (CAPACITY + GRP_SZ - 1) / GRP_SZ;
	localparam int NPAD   = NGRP * GRP_SZ;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_DUP   = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                  cmp;
		logic                  commit;
		logic                  insert;
		logic [VALUE_BITS-1:0] value;
		logic [POS_W-1:0]      rank;
		logic [OCC_W-1:0]      occ;
	} cell_op_t;

	// registered summary of one group of cells
	typedef struct packed {
		logic             any_bound;
		logic             any_eq;
		logic [GRP_W-1:0] off;
	} grp_res_t;

endpackage

FILE: hdl/rss_cell.sv
// ----------------------------------------------------------------------------
// rss_cell
// one slot of the ordered chain: compare flags and neighbor shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rss_cell import rss_pkg::*; (
	input  logic                  clk,
	input  logic [IDX_W-1:0]      idx,
	input  cell_op_t              op,
	input  logic [VALUE_BITS-1:0] prev_val,
	input  logic                  prev_gt,
	input  logic [VALUE_BITS-1:0] next_val,
	output logic [VALUE_BITS-1:0] val,
	output logic                  gt,
	output logic                  bound,
	output logic                  eq
);

	logic [VALUE_BITS-1:0] val_q;
	logic                  gt_q;
	logic                  eq_q;
	logic                  occupied;
	logic                  at_or_after;

	function automatic logic [IDX_W:0] occ_ext(input logic [OCC_W-1:0] o);
		return (IDX_W + 1)'(o);
	endfunction

	assign occupied    = {1'b0, idx} < occ_ext(op.occ);
	assign at_or_after = 32'(idx) >= 32'(op.rank);

	// flags taken once per item, held until commit
	always_ff @(posedge clk) begin
		if (op.cmp) begin
			gt_q <= occupied && (val_q > op.value);
			eq_q <= occupied && (val_q == op.value);
		end
	end

	always_ff @(posedge clk) begin
		if (op.commit) begin
			if (op.insert) begin
				if (!gt_q) begin
					val_q <= prev_gt ? op.value : prev_val;
				end
			end else if (at_or_after) begin
				val_q <= next_val;
			end
		end
	end

	assign val   = val_q;
	assign gt    = gt_q;
	assign eq    = eq_q;
	assign bound = prev_gt && !gt_q;

endmodule

FILE: hdl/rss_grp.sv
// ----------------------------------------------------------------------------
// rss_grp
// registered encoder over one group of cells
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rss_grp import rss_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [GRP_SZ-1:0] bound,
	input  logic [GRP_SZ-1:0] eq,
	output grp_res_t          res
);

	grp_res_t res_q;
	logic [GRP_W-1:0] off;

	// bound is one-hot at most, so an or of indexes is its encoding
	always_comb begin
		off = '0;
		for (int i = 0; i < GRP_SZ; i++) begin
			if (bound[i]) begin
				off = off | GRP_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.any_bound <= |bound;
			res_q.any_eq    <= |eq;
			res_q.off       <= off;
		end
	end

	assign res = res_q;

endmodule

FILE: hdl/ranked_sorted_set.sv
// an input transaction passes the compare, group encode and commit states in order before its result is valid
// one transaction at a time runs through the compare and two-level rank encoder; the next is taken after S_FIN
// the result register lets the next input be taken while a result waits downstream
// reset: arst_n asynchronous active low clears occupancy, control state and result valid
// cell contents are not cleared; slots at or above occupancy are never used
// ----------------------------------------------------------------------------
// ranked_sorted_set
// descending set of distinct values in a chain of cells with rank results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ranked_sorted_set import rss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // value[16:0], rank[26:17], zero[31:27]
	input  logic        s_axis_tuser,  // func (0 insert, 1 delete)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // position[9:0], status[11:10], zero[15:12]
);

	// controller states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_GRP  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]            state_q;
	logic                  func_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [POS_W-1:0]      rank_q;
	logic [OCC_W-1:0]      occ_q;

	logic                  out_valid_q;
	logic [POS_W-1:0]      out_pos_q;
	logic [ST_W-1:0]       out_st_q;

	cell_op_t              op;
	logic                  fin_go;
	logic                  commit;
	logic                  full;
	logic                  dup;
	logic                  range_err;
	logic [31:0]           rank_enc;
	logic [POS_W-1:0]      res_pos;
	logic [ST_W-1:0]       res_st;

	logic [VALUE_BITS-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0]   gt_v;
	logic [NPAD-1:0]       bound_v;
	logic [NPAD-1:0]       eq_v;
	grp_res_t              grp_res [NGRP];
	logic [NGRP-1:0]       grp_bound;

	// input side: one item in flight, accepted only when the controller is free
	assign s_axis_tready = (state_q == S_IDLE);

	// result leaves when the output slot is empty or draining this cycle
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (s_axis_tvalid) state_q <= S_CMP;
				S_CMP:   state_q <= S_GRP;
				S_GRP:   state_q <= S_FIN;
				S_FIN:   if (fin_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item capture, payload only
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_q  <= s_axis_tuser;
			value_q <= s_axis_tdata[VALUE_BITS-1:0];
			rank_q  <= s_axis_tdata[26:17];
		end
	end

	// broadcast to the chain
	assign op.cmp    = (state_q == S_CMP);
	assign op.commit = commit;
	assign op.insert = (func_q == FUNC_INSERT);
	assign op.value  = value_q;
	assign op.rank   = rank_q;
	assign op.occ    = occ_q;

	// chain of cells; cell 0 sees an always-greater neighbor above it
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] pv;
		logic                  pg;
		logic [VALUE_BITS-1:0] nv;

		if (i == 0) begin : g_head
			assign pv = value_q;
			assign pg = 1'b1;
		end else begin : g_body
			assign pv = cell_val[i-1];
			assign pg = gt_v[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign nv = cell_val[i];
		end else begin : g_mid
			assign nv = cell_val[i+1];
		end

		rss_cell u_cell (
			.clk      (clk),
			.idx      (IDX_W'(i)),
			.op       (op),
			.prev_val (pv),
			.prev_gt  (pg),
			.next_val (nv),
			.val      (cell_val[i]),
			.gt       (gt_v[i]),
			.bound    (bound_v[i]),
			.eq       (eq_v[i])
		);
	end

	// pad the last group with empty slots
	for (genvar i = CAPACITY; i < NPAD; i++) begin : g_pad
		assign bound_v[i] = 1'b0;
		assign eq_v[i]    = 1'b0;
	end

	// first level of the rank encoder: one register stage per group
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		rss_grp u_grp (
			.clk   (clk),
			.en    (state_q == S_GRP),
			.bound (bound_v[g*GRP_SZ +: GRP_SZ]),
			.eq    (eq_v[g*GRP_SZ +: GRP_SZ]),
			.res   (grp_res[g])
		);
		assign grp_bound[g] = grp_res[g].any_bound;
	end

	// second level: pick the one group holding the insertion boundary
	always_comb begin
		rank_enc = '0;
		dup      = 1'b0;
		for (int g = 0; g < NGRP; g++) begin
			if (grp_res[g].any_bound) begin
				rank_enc = rank_enc | (32'(g) << GRP_W) | 32'(grp_res[g].off);
			end
			dup = dup | grp_res[g].any_eq;
		end
	end

	// outcome of the item
	assign full      = (occ_q == OCC_W'(CAPACITY));
	assign range_err = 32'(rank_q) >= 32'(occ_q);

	always_comb begin
		res_pos = rank_q;
		res_st  = ST_OK;
		if (func_q == FUNC_INSERT) begin
			if (full) begin
				res_pos = '0;
				res_st  = ST_FULL;
			end else begin
				res_pos = POS_W'(rank_enc);
				res_st  = dup ? ST_DUP : ST_OK;
			end
		end else if (range_err) begin
			res_st = ST_RANGE;
		end
	end

	// chain shifts only on a successful transaction
	assign commit = fin_go && (res_st == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (commit) begin
			if (func_q == FUNC_INSERT) begin
				occ_q <= occ_q + OCC_W'(1);
			end else begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_pos_q <= res_pos;
			out_st_q  <= res_st;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_st_q, out_pos_q};

	// checks
	`include "ranked_sorted_set_assert.svh"

	`RSS_ASSERT(a_occ_bound, 32'(occ_q) <= 32'(CAPACITY), "occupancy above capacity")
	`RSS_NEXT(a_accept_cmp, s_axis_tvalid && s_axis_tready, state_q == S_CMP, "accept did not start compare")
	`RSS_NEXT(a_occ_hold, !commit, occ_q == $past(occ_q), "occupancy moved without commit")
	`RSS_IMPLY(a_bound_onehot, (state_q == S_FIN) && (func_q == FUNC_INSERT) && !full, $onehot(grp_bound), "insert boundary not in exactly one group")
	`RSS_IMPLY(a_dup_rank, (state_q == S_FIN) && (func_q == FUNC_INSERT) && !full && dup, 32'(rank_enc) < 32'(occ_q), "duplicate found beyond occupancy")

endmodule

FILE: bench/ranked_sorted_set_tb.sv
// ----------------------------------------------------------------------------
// ranked_sorted_set_tb
// self-checking bench for the descending ranked set: directed corner cases,
// random insert/delete traffic, a full set and a long output stall, each
// result checked against a queue-based model of the set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ranked_sorted_set_tb;
	import rss_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int IDLE_LIMIT    = 4000;
	localparam int HOLD_CYCLES   = 250;
	localparam int SETTLE_CYCLES = 24;
	localparam int MAX_REPORTS   = 10;
	localparam int PAD_W         = 32 - POS_W - VALUE_BITS;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [ST_W-1:0]  status;
	} set_reply_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;  // value[16:0], rank[26:17], zero[31:27]
	logic        s_axis_tuser  = 1'b0; // func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // position[9:0], status[11:10], zero[15:12]

	// model of the set contents, largest value first
	logic [VALUE_BITS-1:0] held_values[$];
	// results still owed by the block, oldest first
	set_reply_t pending_replies[$];

	int error_count  = 0;
	int quiet_cycles = 0;
	bit calm         = 1'b0;  // no idling on either side
	bit no_gaps      = 1'b0;  // sender offers back to back
	bit hold_off_req = 1'b0;  // asks the sink for one long stall

	ranked_sorted_set uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// apply one operation to the model set and return the result it owes
	function automatic set_reply_t apply_set_op(input logic op,
			input logic [VALUE_BITS-1:0] v, input logic [POS_W-1:0] r);
		set_reply_t reply;
		int above;
		above = 0;
		reply.status = ST_OK;
		if (op == FUNC_INSERT) begin
			if (held_values.size() >= CAPACITY) begin
				reply.status   = ST_FULL;
				reply.position = '0;
			end else begin
				foreach (held_values[i]) begin
					if (held_values[i] > v)
						above++;
				end
				reply.position = POS_W'(above);
				if (above < held_values.size() && held_values[above] == v)
					reply.status = ST_DUP;
				else
					held_values.insert(above, v);
			end
		end else begin
			reply.position = r;
			if (r >= held_values.size())
				reply.status = ST_RANGE;
			else
				held_values.delete(r);
		end
		return reply;
	endfunction

	// mix of small values, values near the top, stored values and anything
	function automatic logic [VALUE_BITS-1:0] pick_value();
		if (held_values.size() > 0 && $urandom_range(0, 4) == 0)
			return held_values[$urandom_range(0, held_values.size() - 1)];
		case ($urandom_range(0, 3))
			0: return VALUE_BITS'($urandom_range(0, 63));
			1: return {VALUE_BITS{1'b1}} - VALUE_BITS'($urandom_range(0, 63));
			default: return VALUE_BITS'($urandom());
		endcase
	endfunction

	// mostly ranks that exist, sometimes any rank the field holds
	function automatic logic [POS_W-1:0] pick_rank();
		if (held_values.size() > 0 && $urandom_range(0, 4) != 0)
			return POS_W'($urandom_range(0, held_values.size() - 1));
		return POS_W'($urandom());
	endfunction

	// offer one transaction, called and returning at a rising edge
	task automatic send_op(input logic op, input logic [VALUE_BITS-1:0] v,
			input logic [POS_W-1:0] r);
		int gap;
		if (!calm && !no_gaps && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 18);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {{PAD_W{1'b0}}, r, v};
		// inputs and tready are stable between the falling and the next rising edge
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
		pending_replies.push_back(apply_set_op(op, v, r));
	endtask

	// unused field gets random bits so it is shown to be ignored
	task automatic send_random_op(input int insert_pct);
		if ($urandom_range(1, 100) <= insert_pct)
			send_op(FUNC_INSERT, pick_value(), POS_W'($urandom()));
		else
			send_op(FUNC_DELETE, VALUE_BITS'($urandom()), pick_rank());
	endtask

	task automatic test_directed();
		send_op(FUNC_DELETE, '0, '0);               // delete on an empty set
		send_op(FUNC_DELETE, '1, '1);               // top rank on an empty set
		send_op(FUNC_INSERT, '1, '0);               // largest value
		send_op(FUNC_INSERT, '0, '1);               // smallest value
		send_op(FUNC_INSERT, '1, '0);               // duplicate at the top
		send_op(FUNC_INSERT, '0, '1);               // duplicate at the bottom
		send_op(FUNC_INSERT, 17'h10000, 10'h155);
		send_op(FUNC_INSERT, 17'h0aaaa, 10'h2aa);
		send_op(FUNC_INSERT, 17'h15555, '0);
		send_op(FUNC_INSERT, 17'h00001, '1);
		send_op(FUNC_DELETE, 17'h0aaaa, 10'd5);     // last entry
		send_op(FUNC_DELETE, 17'h15555, 10'd5);     // one past the end
		send_op(FUNC_DELETE, '0, 10'd2);            // middle entry
		send_op(FUNC_DELETE, '1, '0);               // first entry
		send_op(FUNC_INSERT, 17'h10000, 10'h2aa);   // re-insert a removed value
		send_op(FUNC_INSERT, 17'h15555, 10'h155);   // duplicate at the top
		send_op(FUNC_DELETE, 17'h15555, 10'h200);   // far out of range
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_random_op(55);
	endtask

	// sink stalls for a long stretch while transactions keep coming
	task automatic test_backpressure();
		hold_off_req = 1'b1;
		no_gaps      = 1'b1;
		repeat (40) send_random_op(60);
		no_gaps      = 1'b0;
	endtask

	task automatic test_fill_to_capacity();
		int guard;
		guard = 0;
		while (held_values.size() < CAPACITY && guard < 4 * CAPACITY) begin
			send_op(FUNC_INSERT, VALUE_BITS'($urandom()), POS_W'($urandom()));
			guard++;
		end
		send_op(FUNC_INSERT, held_values[0], '0);   // full wins over duplicate
		send_op(FUNC_INSERT, pick_value(), '1);
		send_op(FUNC_DELETE, '0, '1);               // last rank of a full set
		send_op(FUNC_INSERT, '0, '0);
		send_op(FUNC_INSERT, '1, '0);
		send_op(FUNC_DELETE, '1, '0);
		repeat (20) send_random_op(50);             // churn around capacity
		repeat (20) send_random_op(15);             // drain partway
	endtask

	task automatic test_calm_tail();
		calm = 1'b1;
		repeat (40) send_random_op(45);
	endtask

	initial begin : run_tests
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(60);
		test_backpressure();
		test_fill_to_capacity();
		test_calm_tail();
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// output side ready, with random stalls and one long hold-off on request
	always begin : reply_sink
		int stall;
		@(posedge clk);
		if (hold_off_req) begin
			m_axis_tready <= 1'b0;
			for (int n = 0; n < HOLD_CYCLES; n++)
				@(posedge clk);
			hold_off_req = 1'b0;
			m_axis_tready <= 1'b1;
		end else if (!calm && $urandom_range(0, 24) == 0) begin
			stall = $urandom_range(1, 18);
			m_axis_tready <= 1'b0;
			repeat (stall) @(posedge clk);
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// a transaction seen at the falling edge completes at the next rising edge
	always @(negedge clk) begin : reply_check
		set_reply_t seen;
		set_reply_t want;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (m_axis_tvalid && m_axis_tready) begin
				seen.position = m_axis_tdata[POS_W-1:0];
				seen.status   = m_axis_tdata[POS_W +: ST_W];
				if (pending_replies.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected result: position %0d status %0d",
							seen.position, seen.status);
				end else begin
					want = pending_replies.pop_front();
					if (seen.position !== want.position || seen.status !== want.status) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("result mismatch: position %0d/%0d status %0d/%0d (exp/act)",
								want.position, seen.position, want.status, seen.status);
					end
				end
			end
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule
